@@ hw/rtl/pfrd_pkg.sv @@
// Shared types, codes and helpers for the page framebuffer drawing engine.
package pfrd_pkg;

  localparam int CW         = 11;  // working coordinate width, signed
  localparam int PAGE_ROWS  = 8;
  localparam int PAGE_SHIFT = 3;
  localparam int QDEPTH     = 2;
  localparam int QPW        = $clog2(QDEPTH);

  localparam logic [2:0] FUNC_CLEAR = 3'd0;
  localparam logic [2:0] FUNC_PIXEL = 3'd1;
  localparam logic [2:0] FUNC_HLINE = 3'd2;
  localparam logic [2:0] FUNC_VLINE = 3'd3;
  localparam logic [2:0] FUNC_RECT  = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_PIXEL,
    OP_HLINE,
    OP_VLINE,
    OP_FILL,
    OP_OUTLINE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic [7:0]        w;
    logic [7:0]        h;
    logic              on;
    logic              read_ok;
  } cmd_t;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [2:0] {
    B_INIT,
    B_IDLE,
    B_SETUP,
    B_PIX,
    B_WR,
    B_CLEAR,
    B_READ,
    B_DONE
  } back_state_t;

  function automatic coord_t ext9(input logic [8:0] v);
    return {{(CW-9){v[8]}}, v};
  endfunction

endpackage

@@ hw/rtl/pfrd_cmd_if.sv @@
// Command channel: valid/ready handshake with the drawing command fields.
interface pfrd_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic signed [8:0] pos_x;
  logic signed [8:0] pos_y;
  logic [7:0]        extent_w;
  logic [7:0]        extent_h;
  logic              fill_mode;
  logic              pixel_on;

  modport source (
    output valid, func, pos_x, pos_y, extent_w, extent_h, fill_mode, pixel_on,
    input  ready
  );
  modport sink (
    input  valid, func, pos_x, pos_y, extent_w, extent_h, fill_mode, pixel_on,
    output ready
  );
endinterface

@@ hw/rtl/pfrd_res_if.sv @@
// Result channel: valid/ready handshake with read-back data.
interface pfrd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;

  modport source (output valid, read_data, read_valid, input ready);
  modport sink   (input valid, read_data, read_valid, output ready);
endinterface

@@ hw/rtl/page_framebuffer_rect_draw_top.sv @@
// Top level of the page framebuffer drawing engine: front end, queue, back end.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    func pos_x pos_y extent_w extent_h fill_mode pixel_on
//   res      out  valid/ready    read_data read_valid
//
// Per command the back end takes it from the queue, sets up each segment and
// closes the segment list, does a store read-modify-write for each on-screen
// pixel (over one write and one registered read port) and skips each
// off-screen pixel, then posts the result. A read samples the store only when
// in range; a spare code posts an empty result; clear sweeps the whole store.
// After reset a clearing pass over all SCREEN_W*ceil(SCREEN_H/8) store bytes
// (1024 by default) runs with cmd.ready low. Commands queue two deep while the back
// end works; a stalled res holds one result in its output register.
module page_framebuffer_rect_draw_top
  import pfrd_pkg::*;
#(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  logic       clk,
  input  logic       rst,
  pfrd_cmd_if.sink   cmd,
  pfrd_res_if.source res
);

  logic push_valid;
  logic push_ready;
  cmd_t push_data;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_data;
  logic init_busy;

  pfrd_front #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .init_busy  (init_busy)
  );

  pfrd_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_data   (push_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready),
    .out_data  (pop_data)
  );

  pfrd_back #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_data    (pop_data),
    .init_busy (init_busy),
    .res       (res)
  );

  // The clearing pass starts right out of reset.
  a_init_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> init_busy)
    else $error("clearing pass not running after reset");

  // No command transfer while the store is still being cleared.
  a_no_cmd_during_init: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !(cmd.valid && cmd.ready))
    else $error("command taken during clearing pass");

  // The back end is busy in the cycle after it takes a command.
  a_one_cmd_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> !pop_ready)
    else $error("back end took two commands in a row");

endmodule

@@ hw/rtl/pfrd_front.sv @@
// Front end: takes command transfers and classifies them into queue entries.
module pfrd_front
  import pfrd_pkg::*;
#(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  pfrd_cmd_if.sink cmd,
  output logic     push_valid,
  input  logic     push_ready,
  output cmd_t     push_data,
  input  logic     init_busy
);

  localparam logic [8:0] W_LIM = 9'(SCREEN_W);
  localparam logic [8:0] H_LIM = 9'(SCREEN_H);

  op_t  op;
  logic in_range;

  always_comb begin
    case (cmd.func)
      FUNC_CLEAR: op = OP_CLEAR;
      FUNC_PIXEL: op = OP_PIXEL;
      FUNC_HLINE: op = OP_HLINE;
      FUNC_VLINE: op = OP_VLINE;
      FUNC_RECT:  op = cmd.fill_mode ? OP_FILL : OP_OUTLINE;
      FUNC_READ:  op = OP_READ;
      default:    op = OP_NONE;
    endcase
  end

  // Only the read needs a bounds check up front; draws clip per pixel.
  assign in_range = !cmd.pos_x[8] && ({1'b0, cmd.pos_x[7:0]} < W_LIM) &&
                    !cmd.pos_y[8] && ({1'b0, cmd.pos_y[7:0]} < H_LIM);

  always_comb begin
    push_data.op      = op;
    push_data.x       = cmd.pos_x;
    push_data.y       = cmd.pos_y;
    push_data.w       = cmd.extent_w;
    push_data.h       = cmd.extent_h;
    push_data.on      = cmd.pixel_on;
    push_data.read_ok = (op == OP_READ) && in_range;
  end

  // Hold off transfers while the store is being cleared after reset.
  assign cmd.ready  = push_ready && !init_busy;
  assign push_valid = cmd.valid && !init_busy;

endmodule

@@ hw/rtl/pfrd_cmd_queue.sv @@
// Short command queue between the front end and the drawing back end.
module pfrd_cmd_queue
  import pfrd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);

  cmd_t           slots [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0]   count;
  logic           push;
  logic           pop;

  assign in_ready  = count != (QPW+1)'(QDEPTH);
  assign out_valid = count != '0;
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/pfrd_back.sv @@
// Back end: walks segments pixel by pixel with read-modify-write on the store.
module pfrd_back
  import pfrd_pkg::*;
#(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  cmd_t        q_data,
  output logic        init_busy,
  pfrd_res_if.source  res
);

  localparam int PAGES = (SCREEN_H + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int DEPTH = SCREEN_W * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam coord_t          W_S  = CW'(SCREEN_W);
  localparam coord_t          H_S  = CW'(SCREEN_H);
  localparam logic [AW-1:0]   LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0]   AW_W = AW'(SCREEN_W);

  back_state_t state, state_next;
  cmd_t        cmd_r, cmd_r_next;
  logic [7:0]  seg_idx, seg_idx_next;
  coord_t      cur_x, cur_x_next;
  coord_t      cur_y, cur_y_next;
  logic [7:0]  remain, remain_next;
  logic        vert, vert_next;
  logic [AW-1:0] wr_addr, wr_addr_next;
  logic [2:0]  bit_sel, bit_sel_next;
  logic [AW-1:0] sweep, sweep_next;
  logic        res_valid, res_valid_next;
  logic [7:0]  res_data, res_data_next;
  logic        res_rv, res_rv_next;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_rdata;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  logic          in_screen;
  logic [AW-1:0] pix_addr;
  logic [7:0]    bit_mask;
  logic [7:0]    wr_byte;

  logic [7:0] num_segs;
  coord_t     seg_x;
  coord_t     seg_y;
  logic [7:0] seg_len;
  logic       seg_vert;
  coord_t     bx, by, w_c, h_c;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= mem[mem_raddr];
  end

  assign in_screen = !cur_x[CW-1] && (cur_x < W_S) && !cur_y[CW-1] && (cur_y < H_S);
  assign pix_addr  = AW'(AW'(cur_y[7:PAGE_SHIFT]) * AW_W) + AW'(cur_x[7:0]);
  assign bit_mask  = 8'b1 << bit_sel;
  assign wr_byte   = cmd_r.on ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);

  assign bx  = ext9(cmd_r.x);
  assign by  = ext9(cmd_r.y);
  assign w_c = {{(CW-8){1'b0}}, cmd_r.w};
  assign h_c = {{(CW-8){1'b0}}, cmd_r.h};

  // Segment list of the current command; a filled rectangle is one row per segment.
  always_comb begin
    num_segs = 8'd0;
    seg_x    = bx;
    seg_y    = by;
    seg_len  = cmd_r.w;
    seg_vert = 1'b0;
    case (cmd_r.op)
      OP_PIXEL: begin
        num_segs = 8'd1;
        seg_len  = 8'd1;
      end
      OP_HLINE: num_segs = 8'd1;
      OP_VLINE: begin
        num_segs = 8'd1;
        seg_len  = cmd_r.h;
        seg_vert = 1'b1;
      end
      OP_FILL: begin
        num_segs = cmd_r.h;
        seg_y    = by + {{(CW-8){1'b0}}, seg_idx};
      end
      OP_OUTLINE: begin
        num_segs = 8'd4;
        case (seg_idx[1:0])
          2'd0: seg_y = by;
          2'd1: seg_y = by + h_c - CW'(1);
          2'd2: begin
            seg_len  = cmd_r.h;
            seg_vert = 1'b1;
          end
          default: begin
            seg_x    = bx + w_c - CW'(1);
            seg_len  = cmd_r.h;
            seg_vert = 1'b1;
          end
        endcase
      end
      default: num_segs = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      sweep     <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sweep     <= sweep_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    seg_idx  <= seg_idx_next;
    cur_x    <= cur_x_next;
    cur_y    <= cur_y_next;
    remain   <= remain_next;
    vert     <= vert_next;
    wr_addr  <= wr_addr_next;
    bit_sel  <= bit_sel_next;
    res_data <= res_data_next;
    res_rv   <= res_rv_next;
  end

  always_comb begin
    state_next     = state;
    cmd_r_next     = cmd_r;
    seg_idx_next   = seg_idx;
    cur_x_next     = cur_x;
    cur_y_next     = cur_y;
    remain_next    = remain;
    vert_next      = vert;
    wr_addr_next   = wr_addr;
    bit_sel_next   = bit_sel;
    sweep_next     = sweep;
    res_data_next  = res_data;
    res_rv_next    = res_rv;
    res_valid_next = res_valid && !res.ready;
    q_ready        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = wr_addr;
    mem_wdata      = wr_byte;
    mem_raddr      = pix_addr;

    case (state)
      B_INIT, B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = 8'd0;
        if (sweep == LAST) begin
          state_next = (state == B_INIT) ? B_IDLE : B_DONE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_r_next   = q_data;
          seg_idx_next = 8'd0;
          cur_x_next   = ext9(q_data.x);
          cur_y_next   = ext9(q_data.y);
          case (q_data.op)
            OP_CLEAR: begin
              sweep_next = '0;
              state_next = B_CLEAR;
            end
            OP_READ: state_next = q_data.read_ok ? B_READ : B_DONE;
            OP_NONE: state_next = B_DONE;
            default: state_next = B_SETUP;
          endcase
        end
      end
      B_SETUP: begin
        if (seg_idx == num_segs) begin
          state_next = B_DONE;
        end else begin
          cur_x_next   = seg_x;
          cur_y_next   = seg_y;
          remain_next  = seg_len;
          vert_next    = seg_vert;
          seg_idx_next = seg_idx + 8'd1;
          // Skip zero-length segments straight to the next one.
          state_next   = (seg_len == 8'd0) ? B_SETUP : B_PIX;
        end
      end
      B_PIX: begin
        if (in_screen) begin
          mem_re       = 1'b1;
          wr_addr_next = pix_addr;
          bit_sel_next = cur_y[PAGE_SHIFT-1:0];
          state_next   = B_WR;
        end else if (remain == 8'd1) begin
          state_next = B_SETUP;
        end else begin
          remain_next = remain - 8'd1;
          if (vert) cur_y_next = cur_y + CW'(1);
          else      cur_x_next = cur_x + CW'(1);
        end
      end
      B_WR: begin
        mem_we = 1'b1;
        if (remain == 8'd1) begin
          state_next = B_SETUP;
        end else begin
          remain_next = remain - 8'd1;
          if (vert) cur_y_next = cur_y + CW'(1);
          else      cur_x_next = cur_x + CW'(1);
          state_next = B_PIX;
        end
      end
      B_READ: begin
        mem_re     = 1'b1;
        state_next = B_DONE;
      end
      B_DONE: begin
        // Load the output register once it is empty or being drained.
        if (!res_valid || res.ready) begin
          res_valid_next = 1'b1;
          res_rv_next    = (cmd_r.op == OP_READ) && cmd_r.read_ok;
          res_data_next  = ((cmd_r.op == OP_READ) && cmd_r.read_ok) ? mem_rdata : 8'd0;
          state_next     = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign init_busy      = (state == B_INIT);
  assign res.valid      = res_valid;
  assign res.read_data  = res_data;
  assign res.read_valid = res_rv;

endmodule

@@ test/page_framebuffer_rect_draw_checker.sv @@
// Checker for the page framebuffer drawing engine: mirrors the store, predicts and scores results.
module page_framebuffer_rect_draw_checker
  import pfrd_pkg::*;
#(
  parameter int SCREEN_W = 128,
  parameter int SCREEN_H = 64
) (
  input  logic clk,
  input  logic rst,
  pfrd_cmd_if  cmd,
  pfrd_res_if  res,
  output int   fail_count,
  output int   pending
);

  localparam int PAGES       = (SCREEN_H + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_W * PAGES;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
  } readback_t;

  logic [7:0] page_bytes [STORE_BYTES];
  readback_t  readback_q [$];

  function automatic bit on_screen(int x, int y);
    return x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H;
  endfunction

  function automatic int byte_index(int x, int y);
    return (y / PAGE_ROWS) * SCREEN_W + x;
  endfunction

  // Off-screen pixels are skipped one by one.
  function automatic void plot(int x, int y, bit on);
    if (!on_screen(x, y)) return;
    page_bytes[byte_index(x, y)][y % PAGE_ROWS] = on;
  endfunction

  function automatic void run_row(int x, int y, int len, bit on);
    for (int i = 0; i < len; i++) plot(x + i, y, on);
  endfunction

  function automatic void run_col(int x, int y, int len, bit on);
    for (int i = 0; i < len; i++) plot(x, y + i, on);
  endfunction

  function automatic readback_t draw_command(logic [2:0] func, int x, int y, int w, int h,
                                             bit fill, bit on);
    readback_t rb;
    rb = '0;
    case (func)
      FUNC_CLEAR: foreach (page_bytes[i]) page_bytes[i] = '0;
      FUNC_PIXEL: plot(x, y, on);
      FUNC_HLINE: run_row(x, y, w, on);
      FUNC_VLINE: run_col(x, y, h, on);
      FUNC_RECT: begin
        if (fill) begin
          for (int r = 0; r < h; r++) run_row(x, y + r, w, on);
        end else begin
          // zero height still puts rows at y and y-1; zero width puts columns at x and x-1
          run_row(x, y, w, on);
          run_row(x, y + h - 1, w, on);
          run_col(x, y, h, on);
          run_col(x + w - 1, y, h, on);
        end
      end
      FUNC_READ: begin
        if (on_screen(x, y)) begin
          rb.read_data  = page_bytes[byte_index(x, y)];
          rb.read_valid = 1'b1;
        end
      end
      default: ;
    endcase
    return rb;
  endfunction

  always @(posedge clk) begin
    readback_t want;
    int        x;
    int        y;
    if (rst) begin
      foreach (page_bytes[i]) page_bytes[i] = '0;
      readback_q.delete();
      fail_count = 0;
    end else begin
      // score the result before taking a new command in the same cycle
      if (res.valid && res.ready) begin
        if (readback_q.size() == 0) begin
          $error("result transfer with nothing expected: read_data %0d read_valid %0d",
                 res.read_data, res.read_valid);
          fail_count++;
        end else begin
          want = readback_q.pop_front();
          if (res.read_data !== want.read_data) begin
            $error("read_data expected %0d actual %0d", want.read_data, res.read_data);
            fail_count++;
          end
          if (res.read_valid !== want.read_valid) begin
            $error("read_valid expected %0d actual %0d", want.read_valid, res.read_valid);
            fail_count++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        x = cmd.pos_x;
        y = cmd.pos_y;
        readback_q.push_back(draw_command(cmd.func, x, y, int'(cmd.extent_w),
                                          int'(cmd.extent_h), cmd.fill_mode, cmd.pixel_on));
      end
    end
    pending = readback_q.size();
  end

endmodule

@@ test/page_framebuffer_rect_draw_top_tb.sv @@
// Testbench top for the page framebuffer drawing engine: clock, reset, stimulus and verdict.
module page_framebuffer_rect_draw_top_tb;
  import pfrd_pkg::*;

  localparam int SCREEN_W    = 128;
  localparam int SCREEN_H    = 64;
  localparam int RAND_CMDS   = 1850;
  localparam int STALL_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 64;

  // func codes the block treats as no operation
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   src_idle_pct  = 37;
  int   sink_idle_pct = 37;

  pfrd_cmd_if cmd_ch ();
  pfrd_res_if res_ch ();

  page_framebuffer_rect_draw_top #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  page_framebuffer_rect_draw_checker #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // End the run if no transfer happens on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("page_framebuffer_rect_draw_top verification failed");
    $finish;
  end

  // Call at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input logic [2:0] func, input int x, input int y, input int w,
                          input int h, input int fill, input int on);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     = 1'b1;
    cmd_ch.func      = func;
    cmd_ch.pos_x     = x[8:0];
    cmd_ch.pos_y     = y[8:0];
    cmd_ch.extent_w  = w[7:0];
    cmd_ch.extent_h  = h[7:0];
    cmd_ch.fill_mode = fill[0];
    cmd_ch.pixel_on  = on[0];
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    cmd_ch.valid = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic int pick_coord(int span);
    if ($urandom_range(3) == 0) return int'($urandom_range(511)) - 256;
    return int'($urandom_range(span + 15)) - 8;
  endfunction

  function automatic int pick_extent();
    if ($urandom_range(99) < 4) return int'($urandom_range(255));
    return int'($urandom_range(12));
  endfunction

  initial begin
    int         r;
    logic [2:0] func;
    cmd_ch.valid     = 1'b0;
    cmd_ch.func      = FUNC_CLEAR;
    cmd_ch.pos_x     = '0;
    cmd_ch.pos_y     = '0;
    cmd_ch.extent_w  = '0;
    cmd_ch.extent_h  = '0;
    cmd_ch.fill_mode = 1'b0;
    cmd_ch.pixel_on  = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: corners, clipping, zero lengths, rectangle edge cases, spare codes
    send_cmd(FUNC_READ,  0, 0, 0, 0, 0, 0);
    send_cmd(FUNC_PIXEL, 0, 0, 0, 0, 0, 1);
    send_cmd(FUNC_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 1);
    send_cmd(FUNC_READ,  0, 0, 0, 0, 0, 0);
    send_cmd(FUNC_READ,  SCREEN_W - 1, SCREEN_H - 4, 0, 0, 0, 0);
    send_cmd(FUNC_PIXEL, SCREEN_W, SCREEN_H, 0, 0, 0, 1);
    send_cmd(FUNC_PIXEL, -256, -256, 0, 0, 0, 1);
    send_cmd(FUNC_READ,  255, 255, 0, 0, 0, 0);
    send_cmd(FUNC_READ,  -1, 5, 0, 0, 0, 0);
    send_cmd(FUNC_HLINE, -4, 3, 255, 0, 0, 1);
    send_cmd(FUNC_VLINE, 5, -10, 0, 255, 0, 1);
    send_cmd(FUNC_HLINE, 10, 20, 0, 7, 0, 1);
    send_cmd(FUNC_VLINE, 10, 20, 7, 0, 0, 1);
    send_cmd(FUNC_READ,  10, 16, 0, 0, 0, 0);
    send_cmd(FUNC_RECT,  60, 30, 5, 9, 1, 1);
    send_cmd(FUNC_RECT,  20, 40, 0, 6, 0, 1);
    send_cmd(FUNC_RECT,  30, 50, 4, 0, 0, 1);
    send_cmd(FUNC_RECT,  90, 2, 12, 20, 0, 1);
    send_cmd(FUNC_PIXEL, 60, 30, 0, 0, 1, 0);
    send_cmd(FUNC_READ,  60, 24, 0, 0, 0, 0);
    send_cmd(FUNC_SPARE_A, 255, 255, 255, 255, 1, 1);
    send_cmd(FUNC_SPARE_B, -256, -256, 0, 0, 0, 0);
    send_cmd(FUNC_RECT,  -128, -96, 255, 255, 1, 1);
    send_cmd(FUNC_READ,  64, 32, 0, 0, 0, 0);
    send_cmd(FUNC_CLEAR, 0, 0, 0, 0, 0, 1);
    send_cmd(FUNC_READ,  64, 32, 0, 0, 0, 0);
    send_cmd(FUNC_RECT,  -1, -1, 255, 255, 0, 1);

    for (int n = 0; n < RAND_CMDS; n++) begin
      // long stretch with both sides always ready
      if (n == 600) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (n == 900) begin
        src_idle_pct  = 37;
        sink_idle_pct = 37;
      end
      // hold the sender until the engine has drained
      if (n % 450 == 225) wait_drained();
      r = $urandom_range(99);
      if (r < 30)      func = FUNC_READ;
      else if (r < 50) func = FUNC_PIXEL;
      else if (r < 62) func = FUNC_HLINE;
      else if (r < 74) func = FUNC_VLINE;
      else if (r < 94) func = FUNC_RECT;
      else if (r < 96) func = FUNC_CLEAR;
      else if (r < 98) func = FUNC_SPARE_A;
      else             func = FUNC_SPARE_B;
      send_cmd(func, pick_coord(SCREEN_W), pick_coord(SCREEN_H), pick_extent(), pick_extent(),
               int'($urandom_range(1)), int'($urandom_range(99) < 70));
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("page_framebuffer_rect_draw_top verification clean");
    end else begin
      $display("page_framebuffer_rect_draw_top verification failed");
    end
    $finish;
  end

endmodule
